/* rtl/core/fp64sc_pkg.sv */
// ----------------------------------------------------------------------------
// fp64sc_pkg
// Constants shared by the binary64 power-of-two scaling unit.
// ----------------------------------------------------------------------------
package fp64sc_pkg;

    localparam int unsigned FP_W     = 64;
    localparam int unsigned FRAC_W   = 52;
    localparam int unsigned EXP_W    = 11;
    localparam int unsigned SCALE_W  = 32;
    localparam int unsigned E_W      = 15;
    localparam int unsigned LZ_W     = 6;

    localparam logic [EXP_W-1:0]    EXP_ALL_ONE = 11'h7ff;
    localparam logic signed [E_W-1:0] SCALE_LIMIT = 15'sd5000;
    localparam logic signed [E_W-1:0] MAX_UNB_EXP = 15'sd971;
    localparam logic signed [E_W-1:0] MIN_UNB_EXP = -15'sd1074;
    localparam logic signed [E_W-1:0] EXP_BIAS_LS = 15'sd1075;
    localparam logic signed [E_W-1:0] MAX_SHIFT   = 15'sd54;

    typedef struct packed {
        logic              sign;
        logic              pass;
        logic [FP_W-1:0]   raw;
        logic [FRAC_W:0]   sig;
        logic signed [E_W-1:0] e;
    } fp64sc_op_t;

endpackage

/* rtl/core/fp64_scale_by_power_of_two.sv */
// ----------------------------------------------------------------------------
// fp64_scale_by_power_of_two
// Scales a binary64 pattern by a signed power of two (ldexp), round to
// nearest even on gradual underflow.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; four pipeline stages, each with a valid
// bit, advance together whenever the output stage is free or being taken.
// Reset: rst_n clears all valid bits asynchronously; datapath is not reset.
module fp64_scale_by_power_of_two
    import fp64sc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [63:0] value_bits, [95:64] scale_exponent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] result_bits
);

    logic [3:0] vld_reg;
    logic       adv;

    assign adv      = !vld_reg[3] || m_tready;
    assign s_tready = adv;

    // stage 1: unpack, clamp scale
    fp64sc_op_t      op1_reg, op1_next;
    logic signed [E_W-1:0] sc1_reg, sc1_next;

    always_comb
    begin
        logic [EXP_W-1:0] biased;
        logic signed [SCALE_W-1:0] sc;
        biased = s_tdata[62:52];
        sc     = signed'(s_tdata[95:64]);
        op1_next.raw  = s_tdata[63:0];
        op1_next.sign = s_tdata[63];
        op1_next.pass = (biased == EXP_ALL_ONE) || (s_tdata[62:0] == '0);
        op1_next.sig  = {(biased != '0), s_tdata[51:0]};
        if (biased == '0)
            op1_next.e = MIN_UNB_EXP;
        else
            op1_next.e = signed'({4'd0, biased}) - EXP_BIAS_LS;
        if (sc > SCALE_W'(signed'(SCALE_LIMIT)))
            sc1_next = SCALE_LIMIT;
        else if (sc < -SCALE_W'(signed'(SCALE_LIMIT)))
            sc1_next = -SCALE_LIMIT;
        else
            sc1_next = sc[E_W-1:0];
    end

    // stage 2: leading-zero count, add scale
    fp64sc_op_t op2_reg, op2_next;
    logic [LZ_W-1:0] lz2_reg, lz2_next;

    always_comb
    begin
        lz2_next = '0;
        for (int i = 0; i <= FRAC_W; i++)
            if (op1_reg.sig[i])
                lz2_next = LZ_W'(FRAC_W - i);
        op2_next   = op1_reg;
        op2_next.e = op1_reg.e + sc1_reg;
    end

    // stage 3: normalise
    fp64sc_op_t op3_reg, op3_next;

    always_comb
    begin
        op3_next     = op2_reg;
        op3_next.sig = op2_reg.sig << lz2_reg;
        op3_next.e   = op2_reg.e - signed'({{(E_W-LZ_W){1'b0}}, lz2_reg});
    end

    // stage 4: range select, denormalise and round
    logic [63:0] res_reg, res_next;

    always_comb
    begin
        logic signed [E_W-1:0] s;
        logic [FRAC_W:0] kept;
        logic [FRAC_W+1:0] mask, dropped, half;
        logic [5:0] sh;
        s  = MIN_UNB_EXP - op3_reg.e;
        sh = s[5:0];
        kept    = op3_reg.sig >> sh;
        mask    = ~({(FRAC_W+2){1'b1}} << sh);
        dropped = {1'b0, op3_reg.sig} & mask;
        half    = (FRAC_W+2)'(1) << (sh - 6'd1);
        if (op3_reg.pass)
            res_next = op3_reg.raw;
        else if (op3_reg.e > MAX_UNB_EXP)
            res_next = {op3_reg.sign, EXP_ALL_ONE, 52'd0};
        else if (op3_reg.e >= MIN_UNB_EXP)
        begin
            s = op3_reg.e + EXP_BIAS_LS;
            res_next = {op3_reg.sign, s[EXP_W-1:0], op3_reg.sig[FRAC_W-1:0]};
        end
        else if (s > MAX_SHIFT)
            res_next = {op3_reg.sign, 63'd0};
        else
        begin
            if (dropped > half || (dropped == half && kept[0]))
                kept = kept + 1'b1;
            res_next = {op3_reg.sign, 10'd0, kept};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= op1_next;
            sc1_reg <= sc1_next;
            op2_reg <= op2_next;
            lz2_reg <= lz2_next;
            op3_reg <= op3_next;
            res_reg <= res_next;
        end
    end

    assign m_tvalid = vld_reg[3];
    assign m_tdata  = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted request lost");

endmodule
